@@ sv/cscfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cscfp_pkg
// Shared types and constants of the sensor frame parser.
// ----------------------------------------------------------------------------
package cscfp_pkg;

  localparam logic [2:0] ST_HEADER    = 3'd0;
  localparam logic [2:0] ST_GROUP     = 3'd1;
  localparam logic [2:0] ST_OUTER_BAD = 3'd2;
  localparam logic [2:0] ST_INNER_BAD = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam int MIN_FRAME = 17;
  localparam int HDR_BYTES = 13;
  localparam int LANES     = 4;
  localparam int GRP_AW    = 6;
  localparam int RAM_AW    = GRP_AW + 1;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  typedef struct packed {
    logic [2:0]        status;
    logic [GRP_AW-1:0] groups;
    logic              bank;
    logic [63:0]       node;
    logic [7:0]        device;
    logic [7:0]        func;
    logic [15:0]       start;
    logic [7:0]        count;
  } job_t;

  typedef struct packed {
    logic [LANES-1:0]  we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef logic [LANES-1:0][7:0] lanes_t;

endpackage

@@ sv/crc_checked_sensor_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// crc_checked_sensor_frame_parser_unit
// Sensor frame parser with outer and inner CRC-16/MODBUS checks.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per item, end_of_frame_i on the last byte.
// Output channel: per frame either one error item (status 2..5), or one
// header item followed by one item per four-byte data group; last_of_frame_o
// marks the final item of each frame.
// Bytes are taken at one per cycle while the job queue is not full. Both
// CRCs advance as each byte arrives; the verdict is formed on the final
// byte and queued as a job. The first item of a frame passes through the
// job queue and then the output register; each data group is a buffer read
// followed by an output register load, as the buffer read is registered.
// Up to two finished frames may wait in the job queue; the input stalls
// while both slots are taken, so the next frame starts once emission of
// the older one completes. A stalled output item holds in its register.
// Reset clears counters, CRCs, the job queue and the output valid; the
// group buffer needs no clearing, as only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module crc_checked_sensor_frame_parser_unit #(
  parameter int FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [63:0] node_address_o,
  output logic [7:0]  device_address_o,
  output logic [7:0]  function_code_o,
  output logic [15:0] start_address_o,
  output logic [7:0]  byte_count_o,
  output logic [7:0]  group_name_o,
  output logic [3:0]  type_flags_o,
  output logic [2:0]  decimal_places_o,
  output logic [15:0] data_value_o,
  output logic        last_of_frame_o
);
  import cscfp_pkg::*;

  logic              accept;
  logic              push;
  job_t              push_job;
  job_t              head_job;
  logic              q_valid;
  logic              q_full;
  logic              pop;
  ram_wr_t           wr;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  lanes_t            rd_data;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  cscfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_frame_i(end_of_frame_i),
    .push_o        (push),
    .job_o         (push_job),
    .wr_o          (wr)
  );

  cscfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .valid_o    (q_valid),
    .full_o     (q_full)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cscfp_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr.we[g]),
      .waddr_i(wr.addr),
      .wdata_i(wr.data),
      .re_i   (rd_en),
      .raddr_i(rd_addr),
      .rdata_o(rd_data[g])
    );
  end

  cscfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (head_job),
    .q_valid_i       (q_valid),
    .pop_o           (pop),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .node_address_o  (node_address_o),
    .device_address_o(device_address_o),
    .function_code_o (function_code_o),
    .start_address_o (start_address_o),
    .byte_count_o    (byte_count_o),
    .group_name_o    (group_name_o),
    .type_flags_o    (type_flags_o),
    .decimal_places_o(decimal_places_o),
    .data_value_o    (data_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

@@ sv/cscfp_ram.sv @@
// ----------------------------------------------------------------------------
// cscfp_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cscfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cscfp_front.sv @@
// ----------------------------------------------------------------------------
// cscfp_front
// Byte intake: running CRCs, header capture, group buffer writes and the
// frame verdict pushed to the job queue at the end of each frame.
// ----------------------------------------------------------------------------
module cscfp_front #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_frame_i,
  output logic                push_o,
  output cscfp_pkg::job_t     job_o,
  output cscfp_pkg::ram_wr_t  wr_o
);
  import cscfp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int CMP_W = (CNT_W > GRP_AW) ? CNT_W + 1 : GRP_AW + 1;
  localparam int OFF_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  logic [CNT_W-1:0] n_q;
  logic             ovf_q;
  logic             bank_q;
  logic [15:0]      outer_q, inner_q;
  logic [15:0]      outer_d, inner_d;
  logic [7:0]       hist_q [4];
  logic [63:0]      node_q;
  logic [7:0]       dev_q, fn_q, bc_q;
  logic [15:0]      sa_q;

  logic             room_ok;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] room;
  logic [OFF_W-1:0] off;
  logic             store_ok;
  logic [2:0]       status;
  logic [GRP_AW-1:0] groups;

  always_comb begin
    room_ok  = n_q < CNT_W'(FRAME_BYTES);
    outer_d  = (n_q >= CNT_W'(2))  ? crc_feed(outer_q, hist_q[1]) : outer_q;
    inner_d  = (n_q >= CNT_W'(12)) ? crc_feed(inner_q, hist_q[3]) : inner_q;
    len      = CMP_W'(n_q) + CMP_W'(1);
    room     = (len - CMP_W'(MIN_FRAME)) >> 2;
    off      = OFF_W'(n_q) - OFF_W'(HDR_BYTES);
    store_ok = room_ok && (n_q >= CNT_W'(HDR_BYTES)) && ((off >> 8) == '0);

    if (ovf_q || !room_ok) begin
      status = ST_TOO_LONG;
    end else if (len < CMP_W'(MIN_FRAME)) begin
      status = ST_TOO_SHORT;
    end else if (outer_d != {data_byte_i, hist_q[0]}) begin
      status = ST_OUTER_BAD;
    end else if (inner_d != {hist_q[1], hist_q[2]}) begin
      status = ST_INNER_BAD;
    end else begin
      status = ST_HEADER;
    end

    if (CMP_W'(bc_q[7:2]) > room) begin
      groups = room[GRP_AW-1:0];
    end else begin
      groups = bc_q[7:2];
    end
  end

  assign push_o        = accept_i && end_of_frame_i;
  assign job_o.status  = status;
  assign job_o.groups  = groups;
  assign job_o.bank    = bank_q;
  assign job_o.node    = node_q;
  assign job_o.device  = dev_q;
  assign job_o.func    = fn_q;
  assign job_o.start   = sa_q;
  assign job_o.count   = bc_q;

  always_comb begin
    wr_o.we   = '0;
    wr_o.addr = {bank_q, off[7:2]};
    wr_o.data = data_byte_i;
    if (accept_i && store_ok) begin
      wr_o.we[off[1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      outer_q <= CRC_INIT;
      inner_q <= CRC_INIT;
      hist_q  <= '{default: '0};
      node_q  <= '0;
      dev_q   <= '0;
      fn_q    <= '0;
      sa_q    <= '0;
      bc_q    <= '0;
    end else if (accept_i) begin
      if (room_ok) begin
        hist_q[0] <= data_byte_i;
        hist_q[1] <= hist_q[0];
        hist_q[2] <= hist_q[1];
        hist_q[3] <= hist_q[2];
        n_q       <= n_q + CNT_W'(1);
        outer_q   <= outer_d;
        inner_q   <= inner_d;
        if (n_q < CNT_W'(8)) begin
          node_q <= {node_q[55:0], data_byte_i};
        end
        if (n_q == CNT_W'(8)) begin
          dev_q <= data_byte_i;
        end
        if (n_q == CNT_W'(9)) begin
          fn_q <= data_byte_i;
        end
        if (n_q == CNT_W'(10)) begin
          sa_q[15:8] <= data_byte_i;
        end
        if (n_q == CNT_W'(11)) begin
          sa_q[7:0] <= data_byte_i;
        end
        if (n_q == CNT_W'(12)) begin
          bc_q <= data_byte_i;
        end
      end else begin
        ovf_q <= 1'b1;
      end
      if (end_of_frame_i) begin
        n_q     <= '0;
        ovf_q   <= 1'b0;
        outer_q <= CRC_INIT;
        inner_q <= CRC_INIT;
        bank_q  <= ~bank_q;
      end
    end
  end

endmodule

@@ sv/cscfp_queue.sv @@
// ----------------------------------------------------------------------------
// cscfp_queue
// Two-entry job queue between intake and emission.
// ----------------------------------------------------------------------------
module cscfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cscfp_pkg::job_t push_data_i,
  input  logic            pop_i,
  output cscfp_pkg::job_t head_o,
  output logic            valid_o,
  output logic            full_o
);
  import cscfp_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("job popped from an empty queue");

endmodule

@@ sv/cscfp_back.sv @@
// ----------------------------------------------------------------------------
// cscfp_back
// Emission: header or error item per job, then one item per data group read
// from the group buffer, through a registered output stage.
// ----------------------------------------------------------------------------
module cscfp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cscfp_pkg::job_t          job_i,
  input  logic                     q_valid_i,
  output logic                     pop_o,
  output logic                     rd_en_o,
  output logic [cscfp_pkg::RAM_AW-1:0] rd_addr_o,
  input  cscfp_pkg::lanes_t        rd_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [63:0]              node_address_o,
  output logic [7:0]               device_address_o,
  output logic [7:0]               function_code_o,
  output logic [15:0]              start_address_o,
  output logic [7:0]               byte_count_o,
  output logic [7:0]               group_name_o,
  output logic [3:0]               type_flags_o,
  output logic [2:0]               decimal_places_o,
  output logic [15:0]              data_value_o,
  output logic                     last_of_frame_o
);
  import cscfp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_GROUP} state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] node;
    logic [7:0]  device;
    logic [7:0]  func;
    logic [15:0] start;
    logic [7:0]  count;
    logic [7:0]  name;
    logic [3:0]  flags;
    logic [2:0]  places;
    logic [15:0] value;
    logic        last;
  } item_t;

  state_e            state_q, state_d;
  logic [GRP_AW-1:0] gidx_q, gidx_d;
  item_t             item_q, item_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              load;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    state_d  = state_q;
    gidx_d   = gidx_q;
    item_d   = item_q;
    load     = 1'b0;
    pop_o    = 1'b0;
    rd_en_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          load          = 1'b1;
          item_d        = '0;
          item_d.status = job_i.status;
          item_d.last   = 1'b1;
          if (job_i.status == ST_HEADER) begin
            item_d.node   = job_i.node;
            item_d.device = job_i.device;
            item_d.func   = job_i.func;
            item_d.start  = job_i.start;
            item_d.count  = job_i.count;
            if (job_i.groups != '0) begin
              item_d.last = 1'b0;
              gidx_d      = '0;
              state_d     = S_READ;
            end
          end
          pop_o = item_d.last;
        end
      end
      S_READ: begin
        rd_en_o = 1'b1;
        state_d = S_GROUP;
      end
      S_GROUP: begin
        if (out_free) begin
          load          = 1'b1;
          item_d        = '0;
          item_d.status = ST_GROUP;
          item_d.name   = rd_data_i[0];
          item_d.flags  = rd_data_i[1][7:4];
          item_d.places = rd_data_i[1][2:0];
          item_d.value  = {rd_data_i[2], rd_data_i[3]};
          item_d.last   = gidx_q == (job_i.groups - GRP_AW'(1));
          if (item_d.last) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            gidx_d  = gidx_q + GRP_AW'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  assign rd_addr_o = {job_i.bank, gidx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gidx_q      <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gidx_q      <= gidx_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = item_q.status;
  assign node_address_o   = item_q.node;
  assign device_address_o = item_q.device;
  assign function_code_o  = item_q.func;
  assign start_address_o  = item_q.start;
  assign byte_count_o     = item_q.count;
  assign group_name_o     = item_q.name;
  assign type_flags_o     = item_q.flags;
  assign decimal_places_o = item_q.places;
  assign data_value_o     = item_q.value;
  assign last_of_frame_o  = item_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> load && item_d.last)
    else $error("job retired without its final item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (load && item_d.last) |-> pop_o)
    else $error("final item loaded but job kept");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> q_valid_i)
    else $error("group emission without a pending job");

endmodule

@@ test/crc_checked_sensor_frame_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// crc_checked_sensor_frame_parser_unit_tb
// Self-checking bench for the CRC-checked sensor frame parser. Frames are
// built with correct or damaged outer and inner CRCs and sent one byte per
// item. A behavioral predictor computes the header, group and error items of
// each frame, and every output item is compared field by field in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_sensor_frame_parser_unit_tb;
  import cscfp_pkg::*;

  localparam int FRAME_BYTES = 256;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] node;
    logic [7:0]  device;
    logic [7:0]  func;
    logic [15:0] start;
    logic [7:0]  count;
    logic [7:0]  name;
    logic [3:0]  flags;
    logic [2:0]  places;
    logic [15:0] value;
    logic        last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] node_address_o;
  logic [7:0]  device_address_o;
  logic [7:0]  function_code_o;
  logic [15:0] start_address_o;
  logic [7:0]  byte_count_o;
  logic [7:0]  group_name_o;
  logic [3:0]  type_flags_o;
  logic [2:0]  decimal_places_o;
  logic [15:0] data_value_o;
  logic        last_of_frame_o;

  logic [7:0]  held_bytes [FRAME_BYTES];
  int          held_count = 0;
  bit          held_overflow = 1'b0;
  logic [15:0] outer_sum = 16'hFFFF;
  logic [15:0] inner_sum = 16'hFFFF;
  result_t     pending_results [$];
  result_t     want_item;

  logic [7:0]  frame_buf [$];
  int          items_sent = 0;
  int          results_predicted = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          sink_wait = 0;
  bit          sender_steady = 1'b0;
  bit          sink_steady = 1'b0;

  crc_checked_sensor_frame_parser_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_frame_i   (end_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .node_address_o   (node_address_o),
    .device_address_o (device_address_o),
    .function_code_o  (function_code_o),
    .start_address_o  (start_address_o),
    .byte_count_o     (byte_count_o),
    .group_name_o     (group_name_o),
    .type_flags_o     (type_flags_o),
    .decimal_places_o (decimal_places_o),
    .data_value_o     (data_value_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic void absorb_frame_byte(logic [7:0] b, logic eof);
    int         len;
    int         groups;
    int         p;
    logic [2:0] verdict;
    result_t    r;
    if (held_count < FRAME_BYTES) begin
      held_bytes[held_count] = b;
      if (held_count >= 2) outer_sum = crc16_step(outer_sum, held_bytes[held_count - 2]);
      if (held_count >= 12) inner_sum = crc16_step(inner_sum, held_bytes[held_count - 4]);
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (!eof) return;
    len = held_count;
    verdict = ST_HEADER;
    if (held_overflow) verdict = ST_TOO_LONG;
    else if (len < MIN_FRAME) verdict = ST_TOO_SHORT;
    else if ({held_bytes[len - 1], held_bytes[len - 2]} != outer_sum) verdict = ST_OUTER_BAD;
    else if ({held_bytes[len - 3], held_bytes[len - 4]} != inner_sum) verdict = ST_INNER_BAD;
    r = '0;
    if (verdict != ST_HEADER) begin
      r.status = verdict;
      r.last = 1'b1;
      pending_results.push_back(r);
      results_predicted++;
    end else begin
      groups = int'(held_bytes[12]) / 4;
      if (groups > (len - MIN_FRAME) / 4) groups = (len - MIN_FRAME) / 4;
      r.status = ST_HEADER;
      for (int i = 0; i < 8; i++) r.node = {r.node[55:0], held_bytes[i]};
      r.device = held_bytes[8];
      r.func = held_bytes[9];
      r.start = {held_bytes[10], held_bytes[11]};
      r.count = held_bytes[12];
      r.last = (groups == 0);
      pending_results.push_back(r);
      results_predicted++;
      for (int g = 0; g < groups; g++) begin
        p = HDR_BYTES + 4 * g;
        r = '0;
        r.status = ST_GROUP;
        r.name = held_bytes[p];
        r.flags = held_bytes[p + 1][7:4];
        r.places = held_bytes[p + 1][2:0];
        r.value = {held_bytes[p + 2], held_bytes[p + 3]};
        r.last = (g == groups - 1);
        pending_results.push_back(r);
        results_predicted++;
      end
    end
    held_count = 0;
    held_overflow = 1'b0;
    outer_sum = 16'hFFFF;
    inner_sum = 16'hFFFF;
  endfunction

  task automatic report(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("at %0t: %s", $time, what);
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h expected %0h", results_seen, field, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want_item = pending_results.pop_front();
        check_field("status", 64'(status_o), 64'(want_item.status));
        check_field("node_address", node_address_o, want_item.node);
        check_field("device_address", 64'(device_address_o), 64'(want_item.device));
        check_field("function_code", 64'(function_code_o), 64'(want_item.func));
        check_field("start_address", 64'(start_address_o), 64'(want_item.start));
        check_field("byte_count", 64'(byte_count_o), 64'(want_item.count));
        check_field("group_name", 64'(group_name_o), 64'(want_item.name));
        check_field("type_flags", 64'(type_flags_o), 64'(want_item.flags));
        check_field("decimal_places", 64'(decimal_places_o), 64'(want_item.places));
        check_field("data_value", 64'(data_value_o), 64'(want_item.value));
        check_field("last_of_frame", 64'(last_of_frame_o), 64'(want_item.last));
      end
      results_seen++;
      sink_wait = sink_steady ? 0 : $urandom_range(0, 7);
    end else if (sink_wait != 0) begin
      sink_wait--;
    end
    out_stall_i <= (sink_wait != 0);
  end

  task automatic send_item(logic [7:0] b, logic eof);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_frame_i <= eof;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    absorb_frame_byte(b, eof);
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_item(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic wait_results_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic void fill_random(int n);
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_frame(logic [63:0] node, logic [7:0] dev, logic [7:0] fn,
                                      logic [15:0] start, logic [7:0] cnt, int len);
    fill_random(len);
    for (int i = 0; i < 8; i++) frame_buf[i] = node[8 * (7 - i) +: 8];
    frame_buf[8] = dev;
    frame_buf[9] = fn;
    frame_buf[10] = start[15:8];
    frame_buf[11] = start[7:0];
    frame_buf[12] = cnt;
  endfunction

  // inner_flip damages the inner check value; the outer one always matches
  function automatic void seal_frame(logic [15:0] inner_flip);
    int          n;
    logic [15:0] c;
    n = frame_buf.size();
    c = 16'hFFFF;
    for (int i = 8; i <= n - 5; i++) c = crc16_step(c, frame_buf[i]);
    c ^= inner_flip;
    frame_buf[n - 4] = c[7:0];
    frame_buf[n - 3] = c[15:8];
    c = 16'hFFFF;
    for (int i = 0; i <= n - 3; i++) c = crc16_step(c, frame_buf[i]);
    frame_buf[n - 2] = c[7:0];
    frame_buf[n - 1] = c[15:8];
  endfunction

  task automatic test_header_extremes();
    sender_steady = 1'b1;
    sink_steady = 1'b1;
    build_frame(64'h0, 8'h00, 8'h00, 16'h0000, 8'h00, MIN_FRAME);
    seal_frame(16'h0000);
    send_frame();
    build_frame('1, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, MIN_FRAME);
    seal_frame(16'h0000);
    send_frame();
    build_frame(64'h0123_4567_89AB_CDEF, 8'hA5, 8'h03, 16'h8001, 8'd4, 21);
    seal_frame(16'h0000);
    send_frame();
  endtask

  task automatic test_data_groups();
    logic [31:0] pattern [4];
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5AF8_8001, 32'hA507_7FFE};
    build_frame(64'h8000_0000_0000_0001, 8'h01, 8'h04, 16'h1234, 8'd16, 33);
    for (int g = 0; g < 4; g++)
      for (int k = 0; k < 4; k++) frame_buf[HDR_BYTES + 4 * g + k] = pattern[g][31 - 8 * k -: 8];
    seal_frame(16'h0000);
    send_frame();
    // clamp to the groups present
    build_frame({$urandom(), $urandom()}, 8'h22, 8'h03, 16'h0100, 8'd40, 25);
    seal_frame(16'h0000);
    send_frame();
    // fewer groups than room
    build_frame({$urandom(), $urandom()}, 8'h33, 8'h04, 16'h00FF, 8'd7, 37);
    seal_frame(16'h0000);
    send_frame();
  endtask

  task automatic test_crc_errors();
    build_frame({$urandom(), $urandom()}, 8'h11, 8'h03, 16'h0000, 8'd8, 25);
    seal_frame(16'h0000);
    frame_buf[23] ^= 8'h01;
    send_frame();
    build_frame({$urandom(), $urandom()}, 8'h12, 8'h03, 16'h0000, 8'd8, 25);
    seal_frame(16'h0000);
    frame_buf[24] ^= 8'h80;
    send_frame();
    build_frame({$urandom(), $urandom()}, 8'h13, 8'h03, 16'h0000, 8'd8, 25);
    seal_frame(16'h0001);
    send_frame();
    build_frame({$urandom(), $urandom()}, 8'h14, 8'h03, 16'h0000, 8'd8, 25);
    seal_frame(16'h8000);
    send_frame();
    // both bad: outer wins
    build_frame({$urandom(), $urandom()}, 8'h15, 8'h03, 16'h0000, 8'd8, 25);
    seal_frame(16'h0100);
    frame_buf[24] ^= 8'h01;
    send_frame();
  endtask

  task automatic test_short_frames();
    fill_random(1);
    send_frame();
    fill_random(2);
    send_frame();
    build_frame({$urandom(), $urandom()}, 8'h01, 8'h03, 16'h0000, 8'd0, MIN_FRAME - 1);
    seal_frame(16'h0000);
    send_frame();
  endtask

  task automatic test_frame_limits();
    wait_results_drained();
    build_frame('1, 8'hFF, 8'h10, 16'hFFFF, 8'hFF, FRAME_BYTES);
    seal_frame(16'h0000);
    send_frame();
    build_frame({$urandom(), $urandom()}, 8'h01, 8'h03, 16'h0000, 8'd8, FRAME_BYTES + 1);
    seal_frame(16'h0000);
    send_frame();
    build_frame(64'h0, 8'h7F, 8'h03, 16'h0004, 8'd4, 21);
    seal_frame(16'h0000);
    send_frame();
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int         base_items;
    int         len;
    int         kind;
    logic [7:0] cnt;
    base_items = items_sent;
    while (items_sent - base_items < 150) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) wait_results_drained();
      kind = $urandom_range(0, 99);
      len = $urandom_range(MIN_FRAME, 48);
      if ($urandom_range(0, 1) != 0)
        cnt = 8'(4 * $urandom_range(0, (len - MIN_FRAME) / 4) + $urandom_range(0, 3));
      else
        cnt = 8'($urandom_range(0, 255));
      build_frame({$urandom(), $urandom()}, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), cnt, len);
      if (kind < 80) seal_frame(16'h0000);
      else if (kind < 88) seal_frame(16'h0001 << $urandom_range(0, 15));
      else fill_random($urandom_range(1, MIN_FRAME - 1));
      if (kind >= 72 && kind < 80)
        frame_buf[len - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
      send_frame();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_extremes();
    test_data_groups();
    test_crc_errors();
    test_short_frames();
    test_frame_limits();
    test_random_traffic();
    wait_results_drained();
    repeat (24) @(posedge clk_i);
    if (pending_results.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_results.size()));
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/cscfp_pkg.sv
sv/cscfp_ram.sv
sv/cscfp_front.sv
sv/cscfp_queue.sv
sv/cscfp_back.sv
sv/crc_checked_sensor_frame_parser_unit.sv
test/crc_checked_sensor_frame_parser_unit_tb.sv
